// File: design/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
// Used by every module of the block but the checker; depends on nothing else.
package sfr_pkg;

    // Default sizes of the pattern and replacement windows, in bytes.
    localparam int PATTERN_MAX_DEF     = 8;
    localparam int REPLACEMENT_MAX_DEF = 8;

    // Fixed widths of the configuration registers and the payload.
    localparam int BYTE_W     = 8;
    localparam int TEXT_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd3;

    // Byte sent at the end of every line.
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    // Configuration as seen by the engine, lengths already saturated.
    typedef struct packed {
        logic [TEXT_W-1:0] pat_bytes;
        logic [LEN_W-1:0]  pat_len;
        logic [TEXT_W-1:0] rep_bytes;
        logic [LEN_W-1:0]  rep_len;
    } t_cfg;

    // Request from the engine to the output stage.
    typedef struct packed {
        logic              emit;
        logic              finish;
        logic [BYTE_W-1:0] data;
    } t_emit_req;

endpackage

// File: design/sfr_if.sv
// Valid/ready channel interfaces for the text input and the result output.
// Depends on nothing else.
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: design/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_if, sfr_cfg, sfr_engine and sfr_emit.

// Text arrives one byte per beat and every leftmost, non-overlapping copy of
// the configured pattern is replaced by the replacement text; bytes that may
// still begin a match are held back, and a line_end beat flushes them and
// sends a newline. One item is worked at a time under a small sequencer with
// a single byte comparator. An item is first taken, then the held bytes are
// compared one by one, where a mismatching comparison also sends the
// oldest held byte in the same cycle. A full match then sends the
// replacement bytes. When mismatches have used up every held byte the scan
// ends, and every item ends in a closing state. A line_end beat sends every
// held byte and then the newline. A mismatch restarts the comparisons one
// byte further on, so a rescan adds compares for every byte still held.
// Output back-pressure stalls the sequencer; the output stage keeps one
// byte in hand to mark the last result of each item. Configuration is to be
// written only while the block is idle; the block itself does not enforce
// this. Writing the pattern or its length drops the held bytes.
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sfr_in_if.sink                i_text,
    sfr_out_if.source             o_res
);

    t_cfg      cfg;
    logic      held_clr;
    logic      ack;
    logic      eng_ready;
    t_emit_req req;

    // Configuration registers.
    sfr_cfg #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_held_clr (held_clr)
    );

    // Match engine and sequencer.
    sfr_engine #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_held_clr  (held_clr),
        .i_valid     (i_text.valid),
        .i_text_byte (i_text.text_byte),
        .i_line_end  (i_text.line_end),
        .o_ready     (eng_ready),
        .i_ack       (ack),
        .o_req       (req)
    );

    assign i_text.ready = eng_ready;

    // Output stage.
    sfr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ack   (ack),
        .o_res   (o_res)
    );

endmodule

// File: design/sfr_cfg.sv
// Configuration registers of the find-and-replace block, with length saturation.
// Depends on sfr_pkg.
module sfr_cfg
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_held_clr
);

    localparam logic [LEN_W-1:0] PMAX_L = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] RMAX_L = LEN_W'(REPLACEMENT_MAX);

    logic [TEXT_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]  r_pat_len;
    logic [TEXT_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0]  r_rep_len;

    // Register writes; all registers reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAT_BYTES: r_pat_bytes <= i_cfg_data[TEXT_W-1:0];
                REG_PAT_LEN:   r_pat_len   <= i_cfg_data[LEN_W-1:0];
                REG_REP_BYTES: r_rep_bytes <= i_cfg_data[TEXT_W-1:0];
                REG_REP_LEN:   r_rep_len   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lengths above the window sizes saturate.
    always_comb begin
        o_cfg.pat_bytes = r_pat_bytes;
        o_cfg.rep_bytes = r_rep_bytes;
        o_cfg.pat_len   = (r_pat_len > PMAX_L) ? PMAX_L : r_pat_len;
        o_cfg.rep_len   = (r_rep_len > RMAX_L) ? RMAX_L : r_rep_len;
    end

    // Any change of the pattern drops the held bytes.
    assign o_held_clr = i_cfg_we && (i_cfg_idx == REG_PAT_BYTES || i_cfg_idx == REG_PAT_LEN);

endmodule

// File: design/sfr_emit.sv
// Output stage: keeps one byte back so the last flag can be set on the final
// byte of an item, and drives the output channel. Depends on sfr_pkg.
module sfr_emit
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_emit_req   i_req,
    output logic        o_ack,
    sfr_out_if.source   o_res
);

    logic              r_pend_v;
    logic [BYTE_W-1:0] r_pend_b;
    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_ol;
    logic              out_free;
    logic              push;

    assign out_free = !r_ov || o_res.ready;
    assign o_ack    = !r_pend_v || out_free;
    assign push     = (i_req.emit || i_req.finish) && o_ack && r_pend_v;

    // Pending byte and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_req.emit && o_ack) begin
                r_pend_v <= 1'b1;
            end else if (i_req.finish && o_ack) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob <= r_pend_b;
            r_ol <= i_req.finish;
        end
        if (i_req.emit && o_ack) begin
            r_pend_b <= i_req.data;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.out_byte = r_ob;
    assign o_res.last     = r_ol;

endmodule

// File: design/sfr_engine.sv
// Match engine: held-byte buffer, one shared byte comparator and the sequencer
// that scans, replaces and flushes. Depends on sfr_pkg.
module sfr_engine
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_held_clr,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_line_end,
    output logic              o_ready,
    input  logic              i_ack,
    output t_emit_req         o_req
);

    localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW  = $clog2(PATTERN_MAX + 1);
    localparam int RIW = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;
    localparam int RW  = $clog2(REPLACEMENT_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPL,
        S_FLUSH,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_idx, n_idx;
    logic [RW-1:0]     r_ridx, n_ridx;
    logic [BYTE_W-1:0] r_buf [PATTERN_MAX];

    logic [BYTE_W-1:0] pat_arr [PATTERN_MAX];
    logic [BYTE_W-1:0] rep_arr [REPLACEMENT_MAX];
    logic [CW-1:0]     plen;
    logic [RW-1:0]     rlen;
    logic [CW-1:0]     m_len;
    logic              mismatch;
    logic              idx_last;
    logic              accept;
    logic              do_shift;

    // Byte views of the pattern and the replacement.
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
        assign pat_arr[g] = i_cfg.pat_bytes[g*BYTE_W +: BYTE_W];
    end
    for (genvar g = 0; g < REPLACEMENT_MAX; g++) begin : g_rep
        assign rep_arr[g] = i_cfg.rep_bytes[g*BYTE_W +: BYTE_W];
    end

    assign plen    = i_cfg.pat_len[CW-1:0];
    assign rlen    = i_cfg.rep_len[RW-1:0];
    assign m_len   = (r_cnt < plen) ? r_cnt : plen;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // The shared comparator: one buffer byte against one pattern byte.
    assign mismatch = (plen == '0) || (r_buf[r_idx] != pat_arr[r_idx]);
    assign idx_last = ((CW'(r_idx) + CW'(1)) == m_len);

    // Sequencer next state.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_ridx   = r_ridx;
        o_req    = '0;
        do_shift = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (i_line_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_cnt   = r_cnt + CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else if (mismatch) begin
                    // Oldest byte goes out unchanged; rescan one byte on.
                    o_req.emit = 1'b1;
                    o_req.data = r_buf[0];
                    if (i_ack) begin
                        do_shift = 1'b1;
                        n_cnt    = r_cnt - CW'(1);
                        n_idx    = '0;
                    end
                end else if (idx_last) begin
                    if (r_cnt < plen) begin
                        n_state = S_FIN;
                    end else begin
                        n_ridx  = '0;
                        n_state = S_REPL;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_REPL: begin
                if (r_ridx == rlen) begin
                    // A full match always fills the buffer exactly.
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_state = S_FIN;
                end else begin
                    o_req.emit = 1'b1;
                    o_req.data = rep_arr[r_ridx[RIW-1:0]];
                    if (i_ack) begin
                        n_ridx = r_ridx + RW'(1);
                    end
                end
            end
            S_FLUSH: begin
                o_req.emit = 1'b1;
                if (r_cnt != '0) begin
                    o_req.data = r_buf[0];
                    if (i_ack) begin
                        do_shift = 1'b1;
                        n_cnt    = r_cnt - CW'(1);
                    end
                end else begin
                    o_req.data = NEWLINE_BYTE;
                    if (i_ack) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_req.finish = 1'b1;
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_held_clr) begin
            n_cnt = '0;
        end
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ridx  <= n_ridx;
        end
    end

    // Held-byte buffer: append at the count, shift toward entry zero.
    always_ff @(posedge i_clk) begin
        if (accept && !i_line_end) begin
            r_buf[r_cnt[IW-1:0]] <= i_text_byte;
        end else if (do_shift) begin
            for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

endmodule

// File: design/sfr_checker.sv
// Port-level checks for the find-and-replace block, bound to the top level.
// Depends on the port names of stream_find_replace.
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // One item at a time: the input closes right after a beat is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // When the block is idle, any waiting result closes the previous item.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("idle while an item still has results to send");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_text.valid),
    .i_in_ready  (i_text.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_out_last  (o_res.last)
);
